// ===== hw/rtl/twodm_pkg.sv =====
// constants and widths shared by the three-wheel omni drive mixer
`default_nettype none

package twodm_pkg;

  // command and wheel level widths
  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  // coefficients carry this many fraction bits
  localparam int COEF_BITS = 30;

  // exact wheel sum at 2^-(FRAC_BITS+COEF_BITS) and its magnitude
  localparam int WHEEL_W = 48;
  localparam int MAG_W   = 47;

  // 31-bit signed coefficient words
  localparam int COEF_W = COEF_BITS + 1;

  // 1/sqrt(3) and 0.866, rounded to nearest
  localparam logic signed [COEF_W-1:0] INV_SQRT3_Q30 = 31'sd619925131;
  localparam logic signed [COEF_W-1:0] C0866_Q30     = 31'sd929860420;

endpackage

`default_nettype wire

// ===== hw/rtl/three_wheel_omni_drive_mixer.sv =====
// top level: kiwi drive mixer, pipelined matrix, normalize and divide
`default_nettype none

// Three-wheel omni drive mixer.
// Command channel: drive move_x, move_y, turn_rate (signed Q2.14) and
// use_new_mix, and raise start; a beat is taken at each rising edge with
// start high and busy low. busy stays low, so a beat may enter every cycle.
// Result channel: done is high for exactly one cycle while
// wheel_front_left, wheel_front_right, wheel_back and was_scaled hold the
// result; the receiver cannot stall, so nothing waits and nothing is lost.
// Pipeline: done rises after six stages for pre-sum, constant multiply,
// wheel sum, magnitude, maximum and dividend setup, then one stage per
// quotient bit of the restoring divider (FRAC_BITS+1 stages, three lanes),
// then the output register. Throughput is one beat per cycle, set by the
// fully staged divider lanes.
// Reset (rst, synchronous) clears every stage valid bit; beats in flight
// are dropped and no done pulse follows reset.
module three_wheel_omni_drive_mixer #(
  parameter int FRAC_BITS = 14
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  wire  signed [twodm_pkg::IN_W-1:0]   move_x,
  input  wire  signed [twodm_pkg::IN_W-1:0]   move_y,
  input  wire  signed [twodm_pkg::IN_W-1:0]   turn_rate,
  input  wire                                 use_new_mix,
  output logic                                done,
  output logic signed [twodm_pkg::OUT_W-1:0]  wheel_front_left,
  output logic signed [twodm_pkg::OUT_W-1:0]  wheel_front_right,
  output logic signed [twodm_pkg::OUT_W-1:0]  wheel_back,
  output logic                                was_scaled
);

  localparam int IN_W    = twodm_pkg::IN_W;
  localparam int OUT_W   = twodm_pkg::OUT_W;
  localparam int COEF    = twodm_pkg::COEF_BITS;
  localparam int WHEEL_W = twodm_pkg::WHEEL_W;
  localparam int MAG_W   = twodm_pkg::MAG_W;

  // quotient bits and dividend width
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int NUM_W = MAG_W + Q_W;

  // threshold compare width, wide enough for both m and 1.0
  localparam int CMP_W = (FRAC_BITS + COEF + 1 > MAG_W) ? FRAC_BITS + COEF + 1 : MAG_W;
  localparam logic [CMP_W-1:0] ONE_LVL = {{(CMP_W-1){1'b0}}, 1'b1} << (FRAC_BITS + COEF);

  // rounding bias for the unscaled path
  localparam logic [MAG_W:0] HALF_LSB = {{MAG_W{1'b0}}, 1'b1} << (COEF - 1);

  // one restoring division step on a remainder/dividend word
  function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] rq,
                                                input logic [MAG_W-1:0] dsor);
    logic [MAG_W:0] shifted;
    logic [MAG_W:0] diff;
    logic [MAG_W-1:0] rem;
    logic qbit;
    shifted = {rq[NUM_W-1:Q_W], rq[Q_W-1]};
    diff = shifted - {1'b0, dsor};
    if (shifted >= {1'b0, dsor}) begin
      rem = diff[MAG_W-1:0];
      qbit = 1'b1;
    end else begin
      rem = shifted[MAG_W-1:0];
      qbit = 1'b0;
    end
    return {rem, rq[Q_W-2:0], qbit};
  endfunction

  // every beat is taken
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 1: register command, pre-sums for the sqrt3 matrix
  logic                    s1_vld;
  logic signed [IN_W-1:0]  s1_x, s1_y, s1_t;
  logic                    s1_mode;
  logic signed [IN_W:0]    s1_tx;
  logic signed [IN_W+1:0]  s1_2xt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_x    <= move_x;
    s1_y    <= move_y;
    s1_t    <= turn_rate;
    s1_mode <= use_new_mix;
    s1_tx   <= (IN_W+1)'(move_x) + (IN_W+1)'(turn_rate);
    s1_2xt  <= ((IN_W+2)'(move_x) <<< 1) - (IN_W+2)'(turn_rate);
  end

  // stage 2: constant multiplies
  logic                      s2_vld;
  logic signed [IN_W-1:0]    s2_x, s2_y, s2_t;
  logic                      s2_mode;
  logic signed [IN_W:0]      s2_tx;
  logic signed [WHEEL_W-1:0] s2_py, s2_ptx, s2_p2xt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_x    <= s1_x;
    s2_y    <= s1_y;
    s2_t    <= s1_t;
    s2_mode <= s1_mode;
    s2_tx   <= s1_tx;
    s2_py   <= s1_y * twodm_pkg::C0866_Q30;
    s2_ptx  <= s1_tx * twodm_pkg::INV_SQRT3_Q30;
    s2_p2xt <= s1_2xt * twodm_pkg::INV_SQRT3_Q30;
  end

  // stage 3: wheel sums for the selected matrix
  logic                      s3_vld;
  logic signed [WHEEL_W-1:0] s3_w [3];
  logic signed [WHEEL_W-1:0] x_half, y_one, t_one, tx_one;
  logic signed [WHEEL_W-1:0] w_next [3];

  always_comb begin
    x_half = WHEEL_W'(s2_x) <<< (COEF - 1);
    y_one  = WHEEL_W'(s2_y) <<< COEF;
    t_one  = WHEEL_W'(s2_t) <<< COEF;
    tx_one = WHEEL_W'(s2_tx) <<< COEF;
    if (s2_mode) begin
      w_next[0] = t_one - x_half - s2_py;
      w_next[1] = t_one - x_half + s2_py;
      w_next[2] = tx_one;
    end else begin
      w_next[0] = -s2_ptx - y_one;
      w_next[1] = -s2_ptx + y_one;
      w_next[2] = s2_p2xt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_w[i] <= w_next[i];
    end
  end

  // stage 4: magnitudes and signs
  logic             s4_vld;
  logic [MAG_W-1:0] s4_a [3];
  logic [2:0]       s4_neg;
  logic [WHEEL_W-1:0] abs_full [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_full[i] = s3_w[i][WHEEL_W-1] ? WHEEL_W'(-s3_w[i]) : WHEEL_W'(s3_w[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s4_a[i]   <= abs_full[i][MAG_W-1:0];
      s4_neg[i] <= s3_w[i][WHEEL_W-1];
    end
  end

  // stage 5: largest magnitude
  logic             s5_vld;
  logic [MAG_W-1:0] s5_a [3];
  logic [2:0]       s5_neg;
  logic [MAG_W-1:0] s5_m;
  logic [MAG_W-1:0] max01;

  assign max01 = (s4_a[1] > s4_a[0]) ? s4_a[1] : s4_a[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    s5_a   <= s4_a;
    s5_neg <= s4_neg;
    s5_m   <= (s4_a[2] > max01) ? s4_a[2] : max01;
  end

  // stage 6 (divider stage 0): scale test, dividends, unscaled rounding
  logic             dv_vld    [Q_W+1];
  logic [NUM_W-1:0] dv_rq     [Q_W+1][3];
  logic [MAG_W-1:0] dv_m      [Q_W+1];
  logic             dv_scaled [Q_W+1];
  logic [2:0]       dv_neg    [Q_W+1];
  logic [OUT_W-1:0] dv_u      [Q_W+1][3];
  logic [MAG_W:0]   unscaled_sum [3];
  logic             scaled_next;

  always_comb begin
    scaled_next = CMP_W'(s5_m) > ONE_LVL;
    for (int i = 0; i < 3; i++) begin
      unscaled_sum[i] = {1'b0, s5_a[i]} + HALF_LSB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Q_W; k++) begin
        dv_vld[k] <= 1'b0;
      end
    end else begin
      dv_vld[0] <= s5_vld;
      for (int k = 1; k <= Q_W; k++) begin
        dv_vld[k] <= dv_vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dv_m[0]      <= s5_m;
    dv_scaled[0] <= scaled_next;
    dv_neg[0]    <= s5_neg;
    for (int i = 0; i < 3; i++) begin
      dv_rq[0][i] <= {s5_a[i], {FRAC_BITS{1'b0}}} + NUM_W'(s5_m >> 1);
      dv_u[0][i]  <= unscaled_sum[i][COEF+OUT_W-1:COEF];
    end
    // divider lanes, one quotient bit per stage
    for (int k = 1; k <= Q_W; k++) begin
      dv_m[k]      <= dv_m[k-1];
      dv_scaled[k] <= dv_scaled[k-1];
      dv_neg[k]    <= dv_neg[k-1];
      for (int i = 0; i < 3; i++) begin
        dv_rq[k][i] <= div_step(dv_rq[k-1][i], dv_m[k-1]);
        dv_u[k][i]  <= dv_u[k-1][i];
      end
    end
  end

  // output stage: pick scaled or unscaled level, restore sign
  logic [Q_W+OUT_W-1:0] q_ext [3];
  logic [OUT_W-1:0]     mag_sel [3];
  logic [OUT_W-1:0]     lvl [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_ext[i]   = {{OUT_W{1'b0}}, dv_rq[Q_W][i][Q_W-1:0]};
      mag_sel[i] = dv_scaled[Q_W] ? q_ext[i][OUT_W-1:0] : dv_u[Q_W][i];
      lvl[i]     = dv_neg[Q_W][i] ? OUT_W'(-mag_sel[i]) : mag_sel[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    wheel_front_left  <= lvl[0];
    wheel_front_right <= lvl[1];
    wheel_back        <= lvl[2];
    was_scaled        <= dv_scaled[Q_W];
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the three-wheel omni drive mixer: directed and random commands, scoreboard check
`default_nettype none

module tb;

  localparam int FRAC_BITS  = 14;
  localparam int TAIL_CYC   = 40;
  localparam int STALL_LIM  = 2000;
  localparam int RAND_BEATS = 400;

  // mix coefficients at 30 fraction bits
  localparam longint INV_ROOT3 = 64'sd619925131;
  localparam longint K0866     = 64'sd929860420;
  localparam longint K_HALF    = 64'sd536870912;
  localparam longint K_ONE     = 64'sd1073741824;

  typedef enum logic {MIX_OLD = 1'b0, MIX_120 = 1'b1} mix_mode_t;

  typedef struct packed {
    logic signed [twodm_pkg::IN_W-1:0] x;
    logic signed [twodm_pkg::IN_W-1:0] y;
    logic signed [twodm_pkg::IN_W-1:0] t;
    mix_mode_t                         mode;
    logic                              drain;
  } drive_cmd_t;

  typedef struct packed {
    logic signed [twodm_pkg::OUT_W-1:0] fl;
    logic signed [twodm_pkg::OUT_W-1:0] fr;
    logic signed [twodm_pkg::OUT_W-1:0] bk;
    logic                               scaled;
  } wheel_lvl_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               start = 1'b0;
  logic signed [twodm_pkg::IN_W-1:0]  move_x = '0;
  logic signed [twodm_pkg::IN_W-1:0]  move_y = '0;
  logic signed [twodm_pkg::IN_W-1:0]  turn_rate = '0;
  logic                               use_new_mix = 1'b0;
  wire                                busy;
  wire                                done;
  wire signed [twodm_pkg::OUT_W-1:0]  wheel_front_left;
  wire signed [twodm_pkg::OUT_W-1:0]  wheel_front_right;
  wire signed [twodm_pkg::OUT_W-1:0]  wheel_back;
  wire                                was_scaled;

  drive_cmd_t cmd_q[$];
  wheel_lvl_t wheel_q[$];
  drive_cmd_t cur_cmd;
  drive_cmd_t nxt_cmd;
  int         n_taken = 0;
  int         n_total = 0;
  int         n_bad = 0;
  int         idle_pct;
  int         quiet_cyc = 0;
  wheel_lvl_t got;
  wheel_lvl_t want;

  three_wheel_omni_drive_mixer #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .move_x(move_x), .move_y(move_y), .turn_rate(turn_rate), .use_new_mix(use_new_mix),
    .done(done), .wheel_front_left(wheel_front_left), .wheel_front_right(wheel_front_right),
    .wheel_back(wheel_back), .was_scaled(was_scaled)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // wheel levels for one command: exact sums, then round or normalize by the largest magnitude
  function automatic wheel_lvl_t mix_wheels(drive_cmd_t c);
    longint            sx, sy, st, com;
    longint            w[3];
    longint unsigned   a[3];
    longint unsigned   m, one, r, lev;
    logic signed [15:0] lv[3];
    logic              sc;
    wheel_lvl_t        res;
    sx = $signed(c.x);
    sy = $signed(c.y);
    st = $signed(c.t);
    if (c.mode == MIX_120) begin
      w[0] = -sx * K_HALF - sy * K0866 + st * K_ONE;
      w[1] = -sx * K_HALF + sy * K0866 + st * K_ONE;
      w[2] = (sx + st) * K_ONE;
    end else begin
      com  = -(st + sx) * INV_ROOT3;
      w[0] = com - sy * K_ONE;
      w[1] = com + sy * K_ONE;
      w[2] = (2 * sx - st) * INV_ROOT3;
    end
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (w[i] < 0) ? -w[i] : w[i];
      if (a[i] > m) m = a[i];
    end
    one = 64'd1 << (FRAC_BITS + 30);
    sc  = (m > one);
    for (int i = 0; i < 3; i++) begin
      if (sc) r = ((a[i] << FRAC_BITS) + (m >> 1)) / m;
      else    r = (a[i] + (64'd1 << 29)) >> 30;
      lev   = (w[i] < 0) ? (64'd0 - r) : r;
      lv[i] = lev[15:0];
    end
    res.fl     = lv[0];
    res.fr     = lv[1];
    res.bk     = lv[2];
    res.scaled = sc;
    return res;
  endfunction

  task automatic add_cmd(int x, int y, int t, mix_mode_t mode, logic drain);
    drive_cmd_t c;
    c.x     = x[15:0];
    c.y     = y[15:0];
    c.t     = t[15:0];
    c.mode  = mode;
    c.drain = drain;
    cmd_q.push_back(c);
    n_total++;
  endtask

  // random command level: full range, inside one, extremes, or near the unit boundary
  function automatic logic signed [15:0] pick_level();
    int v;
    int ext[5] = '{-32768, 32767, 0, 16384, -16384};
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = int'($urandom_range(0, 16384)) - 8192;
      2: v = ext[$urandom_range(0, 4)];
      default: begin
        v = 16384 + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v[15:0];
  endfunction

  // sender: takes beats from the pending queue, idles at random per phase
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        wheel_q.push_back(mix_wheels(cur_cmd));
        n_taken++;
      end
      idle_pct = (n_taken < n_total / 3) ? 11 : (n_taken < 2 * n_total / 3) ? 84 : 0;
      if (cmd_q.size() != 0 && int'($urandom_range(1, 100)) > idle_pct &&
          !(cmd_q[0].drain && wheel_q.size() != 0)) begin
        nxt_cmd     = cmd_q.pop_front();
        cur_cmd     = nxt_cmd;
        move_x      <= nxt_cmd.x;
        move_y      <= nxt_cmd.y;
        turn_rate   <= nxt_cmd.t;
        use_new_mix <= nxt_cmd.mode;
        start       <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result checker against the oldest predicted wheel levels
  always @(posedge clk) begin
    if (!rst && done) begin
      got = '{fl: wheel_front_left, fr: wheel_front_right, bk: wheel_back, scaled: was_scaled};
      if (wheel_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: fl=%0d fr=%0d b=%0d scaled=%0b",
                   got.fl, got.fr, got.bk, got.scaled);
      end else begin
        want = wheel_q.pop_front();
        if (got.fl !== want.fl || got.fr !== want.fr || got.bk !== want.bk ||
            got.scaled !== want.scaled) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"mismatch: exp fl=%0d fr=%0d b=%0d scaled=%0b,",
                      " got fl=%0d fr=%0d b=%0d scaled=%0b"},
                     want.fl, want.fr, want.bk, want.scaled,
                     got.fl, got.fr, got.bk, got.scaled);
        end
      end
    end
  end

  // watchdog on cycles with no beat taken and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= STALL_LIM) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  initial begin
    // zero command, exactly one, just above one
    add_cmd(0, 0, 0, MIX_OLD, 1'b0);
    add_cmd(0, 0, 0, MIX_120, 1'b0);
    add_cmd(0, 0, 16384, MIX_120, 1'b0);
    add_cmd(0, 0, -16384, MIX_120, 1'b0);
    add_cmd(0, 16384, 0, MIX_OLD, 1'b0);
    add_cmd(0, -16384, 0, MIX_OLD, 1'b0);
    add_cmd(0, 16385, 0, MIX_OLD, 1'b0);
    add_cmd(16384, 0, 0, MIX_120, 1'b0);
    // largest magnitude on a negative wheel
    add_cmd(-32768, 0, 0, MIX_120, 1'b0);
    add_cmd(-16385, 0, 0, MIX_120, 1'b0);
    // field extremes in both modes, then single-LSB commands
    add_cmd(32767, 32767, 32767, MIX_OLD, 1'b0);
    add_cmd(32767, 32767, 32767, MIX_120, 1'b0);
    add_cmd(-32768, -32768, -32768, MIX_OLD, 1'b0);
    add_cmd(-32768, -32768, -32768, MIX_120, 1'b0);
    add_cmd(32767, -32768, 32767, MIX_120, 1'b0);
    add_cmd(-32768, 32767, -32768, MIX_OLD, 1'b0);
    add_cmd(0, 0, 1, MIX_OLD, 1'b0);
    add_cmd(1, -1, 1, MIX_120, 1'b0);
    // random commands, with a full drain before some of them
    for (int i = 0; i < RAND_BEATS; i++)
      add_cmd(pick_level(), pick_level(), pick_level(), mix_mode_t'($urandom_range(0, 1)),
              i == 0 || i == 150 || i == 300);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (n_taken < n_total || wheel_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (n_bad == 0 && wheel_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
